// ----- hw/rtl/icce_pkg.sv -----
// icce_pkg: shared types and fixed constants of the clamped-edge convolution block.
// No dependencies; imported by the top level.
package icce_pkg;

   localparam int PIX_W       = 8;
   localparam int COEF_W      = 12;
   localparam int KROW_W      = 60;
   localparam int KROWS       = 5;
   localparam int DIV_W       = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int ROW_W       = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CNT_W       = 29;
   localparam int PIX_MAX     = 255;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_ROW0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_ROW1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_ROW2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_ROW3 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_ROW4 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIVISOR     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IN_CNT,
      ST_OUT_CNT,
      ST_DECIDE,
      ST_TAP,
      ST_SCALE,
      ST_LAUNCH,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

// ----- hw/rtl/icce_ram.sv -----
// icce_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module icce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/icce_div_cell.sv -----
// icce_div_cell: one restoring division step, registered.
// No dependencies; instantiated by icce_div_chain.
module icce_div_cell #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             src_valid,
   input  logic [DEN_W-1:0] src_rem,
   input  logic [NUM_W-1:0] src_num,
   input  logic [DEN_W-1:0] src_den,
   input  logic [NUM_W-1:0] src_quo,
   output logic             dst_valid,
   output logic [DEN_W-1:0] dst_rem,
   output logic [NUM_W-1:0] dst_num,
   output logic [DEN_W-1:0] dst_den,
   output logic [NUM_W-1:0] dst_quo
);

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             take;
   logic             valid_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff, quo_in;

   always_comb begin
      trial  = {src_rem, src_num[NUM_W-1]};
      diff   = trial - {1'b0, src_den};
      take   = trial >= {1'b0, src_den};
      rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_in = {src_num[NUM_W-2:0], 1'b0};
      quo_in = {src_quo[NUM_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= src_den;
      quo_ff <= quo_in;
   end

   assign dst_valid = valid_ff;
   assign dst_rem   = rem_ff;
   assign dst_num   = num_ff;
   assign dst_den   = den_ff;
   assign dst_quo   = quo_ff;

endmodule

// ----- hw/rtl/icce_div_chain.sv -----
// icce_div_chain: unsigned divider built as a row of icce_div_cell, one quotient bit per cell.
// Depends on icce_div_cell.
module icce_div_chain #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   logic             v   [NUM_W+1];
   logic [DEN_W-1:0] rem [NUM_W+1];
   logic [NUM_W-1:0] nm  [NUM_W+1];
   logic [DEN_W-1:0] dn  [NUM_W+1];
   logic [NUM_W-1:0] q   [NUM_W+1];

   assign v[0]   = start;
   assign rem[0] = '0;
   assign nm[0]  = num;
   assign dn[0]  = den;
   assign q[0]   = '0;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      icce_div_cell #(
         .NUM_W (NUM_W),
         .DEN_W (DEN_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (v[i]),
         .src_rem   (rem[i]),
         .src_num   (nm[i]),
         .src_den   (dn[i]),
         .src_quo   (q[i]),
         .dst_valid (v[i+1]),
         .dst_rem   (rem[i+1]),
         .dst_num   (nm[i+1]),
         .dst_den   (dn[i+1]),
         .dst_quo   (q[i+1])
      );
   end

   assign done = v[NUM_W];
   assign quo  = q[NUM_W];

endmodule

// ----- hw/rtl/image_convolve_clamped_edges.sv -----
// image_convolve_clamped_edges: 2-D convolution with replicated borders, top level.
// Depends on icce_pkg, icce_ram and icce_div_chain.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata = pixel_in, tuser = mode (1 = drain)
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata = pixel_out, tlast = end_of_line,
//          |     |                        | tuser = end_of_frame
//  csr     | in  | csr_we                 | csr_addr = register index, csr_wdata = value
//
// Steps: one item at a time. An item that yields no result passes the accept, input-count,
// output-count and decide steps and returns to idle. An item that yields a result adds the tap
// reads and accumulation (one line-store read port, one tap per cycle), a scaling step and
// an emit step; a positive sum also passes a launch step and the divider chain, one cell per
// quotient bit for NUM_W = 20+clog2(KERNEL_SIZE^2) bits, a zero or negative one skips them.
// Reset: synchronous, clears row, column, slot and tap counters, the FSM and the output valid flag; no clearing pass.
// Stalls: while a result waits in the output register, the next result is held in the emit
// step and input transfers stop until the waiting one leaves.
module image_convolve_clamped_edges #(
   parameter int KERNEL_SIZE = 3,
   parameter int MAX_WIDTH   = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [icce_pkg::PIX_W-1:0]      req_tdata,   // [7:0] pixel_in
   input  logic                            req_tuser,   // [0] mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [icce_pkg::PIX_W-1:0]      rsp_tdata,   // [7:0] pixel_out
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,   // [0] end_of_frame
   input  logic                            csr_we,
   input  logic [icce_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [icce_pkg::KROW_W-1:0]     csr_wdata
);

   import icce_pkg::*;

   localparam int KK    = KERNEL_SIZE * KERNEL_SIZE;
   localparam int MID   = KERNEL_SIZE / 2;
   localparam int LAG_A = KERNEL_SIZE - 1 - KERNEL_SIZE / 2;
   localparam int RING  = 2 * KERNEL_SIZE;          // line-store rows in the ring
   localparam int SW    = $clog2(RING);
   localparam int SSW   = SW + 3;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int XW    = ((CW > WIDTH_REG_W) ? CW : WIDTH_REG_W) + 2;
   localparam int RW    = ROW_W + 2;
   localparam int TW    = $clog2(KERNEL_SIZE + 1);
   localparam int AW    = COEF_W + PIX_W + 1 + $clog2(KK);
   localparam int NW    = AW - 1;
   localparam int MW    = COEF_W + 1 + $clog2(KK);
   localparam int DW    = DIV_W + MW;
   localparam int ADW   = SW + CW;
   localparam int DEPTH = RING << CW;

   // configuration
   logic [KROW_W-1:0]      kernel_ff [KROWS];
   logic [DIV_W-1:0]       divisor_ff;
   logic [WIDTH_REG_W-1:0] width_ff;
   logic [ROW_W-1:0]       height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KROWS; i++) begin
            kernel_ff[i] <= '0;
         end
         divisor_ff <= DIV_W'(1);
         width_ff   <= WIDTH_REG_W'(1024);
         height_ff  <= ROW_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_KERNEL_ROW0:  kernel_ff[0] <= csr_wdata;
            CSR_KERNEL_ROW1:  kernel_ff[1] <= csr_wdata;
            CSR_KERNEL_ROW2:  kernel_ff[2] <= csr_wdata;
            CSR_KERNEL_ROW3:  kernel_ff[3] <= csr_wdata;
            CSR_KERNEL_ROW4:  kernel_ff[4] <= csr_wdata;
            CSR_DIVISOR:      divisor_ff   <= csr_wdata[DIV_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff     <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff    <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size and divisor: zero reads as one, width capped at the line length
   logic [WIDTH_REG_W-1:0] w_eff;
   logic [ROW_W-1:0]       h_eff;
   logic [DIV_W-1:0]       div_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_REG_W'(1);
      end else if (XW'(width_ff) > XW'(MAX_WIDTH)) begin
         w_eff = WIDTH_REG_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff   = (height_ff == '0) ? ROW_W'(1) : height_ff;
      div_eff = (divisor_ff == '0) ? DIV_W'(1) : divisor_ff;
   end

   // state
   state_type        state_ff, state_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SW-1:0]    in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [CNT_W-1:0] in_cnt_ff, in_cnt_in, out_idx_ff, out_idx_in;
   logic             eol_ff, eol_in, eof_ff, eof_in;
   logic [TW-1:0]    tap_r_ff, tap_r_in, tap_c_ff, tap_c_in;
   logic [TW-1:0]    lk_r_ff, lk_r_in, lk_c_ff, lk_c_in;
   logic             rd_pend_ff, rd_pend_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [MW-1:0]    mag_ff, mag_in;
   logic [NW-1:0]    num_ff, num_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [PIX_W-1:0] result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic             rsp_last_ff, rsp_last_in, rsp_user_ff, rsp_user_in;

   // frame wrap seen at the start of a step
   logic             wrap_now;
   logic [ROW_W-1:0] wr_in_row;
   logic [CW-1:0]    wr_in_col;
   logic [SW-1:0]    wr_in_slot;
   logic [XW-1:0]    in_col_nx;

   always_comb begin
      wrap_now   = (in_row_ff >= h_eff) && (out_row_ff >= h_eff);
      wr_in_row  = wrap_now ? '0 : in_row_ff;
      wr_in_col  = wrap_now ? '0 : in_col_ff;
      wr_in_slot = wrap_now ? '0 : in_slot_ff;
      in_col_nx  = XW'(wr_in_col) + XW'(1);
   end

   // next output position and end-of-step wrap after an emitted result
   logic [XW-1:0]    out_col_nx;
   logic             out_eol;
   logic [ROW_W-1:0] out_row_nx;
   logic [SW-1:0]    out_slot_nx;
   logic             end_wrap;

   always_comb begin
      out_col_nx  = XW'(out_col_ff) + XW'(1);
      out_eol     = out_col_nx >= XW'(w_eff);
      out_row_nx  = out_eol ? out_row_ff + ROW_W'(1) : out_row_ff;
      if (!out_eol) begin
         out_slot_nx = out_slot_ff;
      end else if (out_slot_ff == SW'(RING - 1)) begin
         out_slot_nx = '0;
      end else begin
         out_slot_nx = out_slot_ff + SW'(1);
      end
      end_wrap = (in_row_ff >= h_eff) && (out_row_nx >= h_eff);
   end

   // tap address: clamp row and column to the frame, row mapped to its ring slot
   logic signed [XW-1:0]  ic_s, ic_cl, w_s;
   logic signed [RW-1:0]  ir_s, ir_cl, h_s, d_s;
   logic signed [SSW-1:0] slot_s;
   logic [SW-1:0]         rd_slot;
   logic [ADW-1:0]        rd_addr, wr_addr;

   always_comb begin
      w_s  = $signed(XW'(w_eff));
      ic_s = $signed(XW'(out_col_ff)) + $signed(XW'(tap_c_ff)) - $signed(XW'(MID));
      if (ic_s < 0) begin
         ic_cl = '0;
      end else if (ic_s > w_s - 1) begin
         ic_cl = w_s - 1;
      end else begin
         ic_cl = ic_s;
      end
      h_s  = $signed(RW'(h_eff));
      ir_s = $signed(RW'(out_row_ff)) + $signed(RW'(tap_r_ff)) - $signed(RW'(MID));
      if (ir_s < 0) begin
         ir_cl = '0;
      end else if (ir_s > h_s - 1) begin
         ir_cl = h_s - 1;
      end else begin
         ir_cl = ir_s;
      end
      // offset from the current output row stays within half a kernel
      d_s    = ir_cl - $signed(RW'(out_row_ff));
      slot_s = $signed(SSW'(out_slot_ff)) + SSW'(d_s);
      if (slot_s < 0) begin
         rd_slot = SW'(slot_s + $signed(SSW'(RING)));
      end else if (slot_s >= $signed(SSW'(RING))) begin
         rd_slot = SW'(slot_s - $signed(SSW'(RING)));
      end else begin
         rd_slot = SW'(slot_s);
      end
      rd_addr = {rd_slot, ic_cl[CW-1:0]};
      wr_addr = {wr_in_slot, wr_in_col};
   end

   // line store
   logic             ram_we, ram_re;
   logic [PIX_W-1:0] ram_rdata;

   icce_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // coefficient of the tap whose pixel is arriving
   logic [KROW_W-1:0]        krow_sel;
   logic signed [COEF_W-1:0] coef;
   logic [COEF_W:0]          coef_abs;
   logic signed [COEF_W+PIX_W:0] prod;

   always_comb begin
      krow_sel = kernel_ff[3'(lk_r_ff)] >> (COEF_W * lk_c_ff);
      coef     = $signed(krow_sel[COEF_W-1:0]);
      coef_abs = coef[COEF_W-1] ? (COEF_W+1)'(-$signed((COEF_W+1)'(coef)))
                                : (COEF_W+1)'(coef);
      prod     = coef * $signed({1'b0, ram_rdata});
   end

   // divider: sum over (divisor * sum of magnitudes), both truncations folded into one
   logic          div_go, div_done;
   logic [NW-1:0] div_quo;
   logic [MW-1:0] mag_eff;

   assign mag_eff = (mag_ff == '0) ? MW'(1) : mag_ff;

   icce_div_chain #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      in_slot_in   = in_slot_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_slot_in  = out_slot_ff;
      in_cnt_in    = in_cnt_ff;
      out_idx_in   = out_idx_ff;
      eol_in       = eol_ff;
      eof_in       = eof_ff;
      tap_r_in     = tap_r_ff;
      tap_c_in     = tap_c_ff;
      lk_r_in      = lk_r_ff;
      lk_c_in      = lk_c_ff;
      rd_pend_in   = 1'b0;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_go       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               in_row_in   = wr_in_row;
               in_col_in   = wr_in_col;
               in_slot_in  = wr_in_slot;
               out_row_in  = wrap_now ? '0 : out_row_ff;
               out_col_in  = wrap_now ? '0 : out_col_ff;
               out_slot_in = wrap_now ? '0 : out_slot_ff;
               // a pixel past the frame's last line acts as a drain
               if (!req_tuser && (wr_in_row < h_eff)) begin
                  ram_we = 1'b1;
                  if (in_col_nx >= XW'(w_eff)) begin
                     in_col_in = '0;
                     in_row_in = wr_in_row + ROW_W'(1);
                     in_slot_in = (wr_in_slot == SW'(RING - 1)) ? '0 : wr_in_slot + SW'(1);
                  end else begin
                     in_col_in = CW'(in_col_nx);
                  end
               end
               state_in = ST_IN_CNT;
            end
         end
         ST_IN_CNT: begin
            in_cnt_in = CNT_W'(in_row_ff) * CNT_W'(w_eff) + CNT_W'(in_col_ff);
            state_in  = ST_OUT_CNT;
         end
         ST_OUT_CNT: begin
            out_idx_in = CNT_W'(out_row_ff) * CNT_W'(w_eff) + CNT_W'(out_col_ff);
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            eol_in = out_eol;
            eof_in = out_eol && ((ROW_W+1)'(out_row_ff) + (ROW_W+1)'(1) >= (ROW_W+1)'(h_eff));
            if ((out_row_ff < h_eff) &&
                ((in_row_ff >= h_eff) ||
                 (in_cnt_ff >= out_idx_ff + CNT_W'(LAG_A) * CNT_W'(w_eff)
                               + CNT_W'(LAG_A) + CNT_W'(1)))) begin
               tap_r_in = '0;
               tap_c_in = '0;
               acc_in   = '0;
               mag_in   = '0;
               state_in = ST_TAP;
            end else begin
               if (wrap_now) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  in_slot_in  = '0;
                  out_row_in  = '0;
                  out_col_in  = '0;
                  out_slot_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_TAP: begin
            if (tap_r_ff != TW'(KERNEL_SIZE)) begin
               ram_re     = 1'b1;
               rd_pend_in = 1'b1;
               lk_r_in    = tap_r_ff;
               lk_c_in    = tap_c_ff;
               if (tap_c_ff == TW'(KERNEL_SIZE - 1)) begin
                  tap_c_in = '0;
                  tap_r_in = tap_r_ff + TW'(1);
               end else begin
                  tap_c_in = tap_c_ff + TW'(1);
               end
            end
            if (rd_pend_ff) begin
               acc_in = acc_ff + AW'(prod);
               mag_in = mag_ff + MW'(coef_abs);
            end else if (tap_r_ff == TW'(KERNEL_SIZE)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            den_in = DW'(div_eff) * DW'(mag_eff);
            num_in = acc_ff[NW-1:0];
            // zero or negative sums truncate to at most zero and clamp to zero
            if (!acc_ff[AW-1] && (acc_ff != '0)) begin
               state_in = ST_LAUNCH;
            end else begin
               result_in = '0;
               state_in  = ST_EMIT;
            end
         end
         ST_LAUNCH: begin
            div_go   = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               result_in = (div_quo > NW'(PIX_MAX)) ? PIX_W'(PIX_MAX) : div_quo[PIX_W-1:0];
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = result_ff;
               rsp_last_in  = eol_ff;
               rsp_user_in  = eof_ff;
               if (end_wrap) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  in_slot_in  = '0;
                  out_row_in  = '0;
                  out_col_in  = '0;
                  out_slot_in = '0;
               end else begin
                  out_row_in  = out_row_nx;
                  out_col_in  = out_eol ? '0 : CW'(out_col_nx);
                  out_slot_in = out_slot_nx;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_slot_ff  <= '0;
         tap_r_ff     <= '0;
         tap_c_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_slot_ff  <= out_slot_in;
         tap_r_ff     <= tap_r_in;
         tap_c_ff     <= tap_c_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_cnt_ff    <= in_cnt_in;
      out_idx_ff   <= out_idx_in;
      eol_ff       <= eol_in;
      eof_ff       <= eof_in;
      lk_r_ff      <= lk_r_in;
      lk_c_ff      <= lk_c_in;
      acc_ff       <= acc_in;
      mag_ff       <= mag_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      result_ff    <= result_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EMIT))
      else $error("result register loaded outside the emit step");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider result arrived while not awaited");

   a_slots_in_ring: assert property (@(posedge clock) disable iff (reset)
      (in_slot_ff < SW'(RING)) && (out_slot_ff < SW'(RING)))
      else $error("line-store ring slot out of range");

   a_accept_starts_step: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_IN_CNT) && !rd_pend_ff)
      else $error("input transfer did not start a step");
`endif

endmodule
